FILE: src/dcd_pkg.sv
// Shared types and constants for the dwell click detector.
// No dependencies.
`default_nettype none

package dcd_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_MUL,
    S_DIV,
    S_STEP,
    S_OUT
  } dcd_state_t;

  // Indicator action codes
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SHOW   = 2'd1,
    ACT_HIDE   = 2'd2,
    ACT_UPDATE = 2'd3
  } dcd_action_t;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_DWELL   = 2'd1;
  localparam logic [1:0] REG_SETTLE  = 2'd2;

  localparam int CFG_ADDR_BITS = 4;
  localparam int DELAY_BITS    = 14;
  localparam int SETTLE_BITS   = 3;
  localparam int PROG_BITS     = 10;
  localparam int NUM_BITS      = DELAY_BITS + PROG_BITS;

  localparam logic [DELAY_BITS-1:0]  DWELL_RESET  = 14'd1000;
  localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 3'd1;

  localparam int MOVE_THRESHOLD     = 5;
  localparam int UPDATE_INTERVAL_MS = 50;
  localparam int MIN_PROGRESS_STEP  = 30;
  localparam int PERMILLE_FULL      = 1000;
  localparam int MS_PER_SECOND      = 1000;

  // One quotient bit per step; quotient stays below 1024
  localparam logic [3:0] DIV_LAST = 4'(PROG_BITS - 1);

endpackage

`default_nettype wire

FILE: src/dwell_click_detector_unit.sv
// Dwell click detector, top level.
// Depends on dcd_pkg.
`default_nettype none

// Dwell click detector. Every input transfer yields exactly one result transfer.
// A sample (in_cmd = 0) carries a pointer position and a free-running millisecond
// tick; a hotkey (in_cmd = 1) toggles the armed flag. Moving more than 5 pixels
// on either axis re-anchors the position and time and hides the indicator. Held
// still while armed, the block shows the indicator after settle_seconds, then
// reports per-mille progress (at most every 50 ms, and after the first figure only
// on a change of 30 or more), and after settle time plus dwell_delay_ms emits one
// click per stop. An item is latched, then passes CALC and DECIDE; one that needs
// a progress figure goes on through MUL, DIV (the per-mille divide runs one
// quotient bit per cycle on a single shared subtractor) and STEP, and all reach
// OUT, which waits while the output register holds a stalled result. The input
// side stalls while an item is being worked; the result sits in an output
// register, so the next item may be taken while the last result waits.
// Registers (APB, 32-bit data, byte address 4*i, pready tied high):
//   0x0 enabled, 0x4 dwell_delay_ms (14 bits), 0x8 settle_seconds (3 bits).
// Write registers only while the block is idle.
module dwell_click_detector_unit
  import dcd_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic        [31:0]           in_now_ms,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_click,
  output logic             [1:0]            out_indicator_action,
  output logic signed      [COORD_BITS-1:0] out_show_x,
  output logic signed      [COORD_BITS-1:0] out_show_y,
  output logic             [PROG_BITS-1:0]  out_progress_permille,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic        [31:0]           pwdata,
  output logic             [31:0]           prdata,
  output logic                              pready
);

  localparam int DW = COORD_BITS + 1;
  localparam logic signed [DW-1:0] MOVE_POS = DW'(MOVE_THRESHOLD);
  localparam logic signed [DW-1:0] MOVE_NEG = -DW'(MOVE_THRESHOLD);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                   enabled_r;
  logic [DELAY_BITS-1:0]  delay_r;
  logic [SETTLE_BITS-1:0] settle_r;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      delay_r   <= DWELL_RESET;
      settle_r  <= SETTLE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLED: enabled_r <= pwdata[0];
        REG_DWELL:   delay_r   <= pwdata[DELAY_BITS-1:0];
        REG_SETTLE:  settle_r  <= pwdata[SETTLE_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLED: prdata = {31'd0, enabled_r};
      REG_DWELL:   prdata = {{(32-DELAY_BITS){1'b0}}, delay_r};
      REG_SETTLE:  prdata = {{(32-SETTLE_BITS){1'b0}}, settle_r};
      default:     prdata = 32'd0;
    endcase
  end

  // settle, total ms; user, not block, keeps both fixed while an item is worked
  logic [12:0] settle_ms;
  logic [14:0] total_ms;
  assign settle_ms = 13'(settle_r) * 13'(MS_PER_SECOND);
  assign total_ms  = 15'(settle_ms) + 15'(delay_r);

  // ---------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------
  dcd_state_t state_r, state_nxt;

  // latched item
  logic                  cmd_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [31:0]           now_r;

  // detector state
  logic                  primed_r, primed_nxt;
  logic                  armed_r, armed_nxt;
  logic                  fired_r, fired_nxt;
  logic                  ind_on_r, ind_on_nxt;
  logic                  lp_valid_r, lp_valid_nxt;   // clear = no progress shown
  logic [PROG_BITS-1:0]  lp_r, lp_nxt;
  logic [COORD_BITS-1:0] anchor_x_r, anchor_x_nxt;
  logic [COORD_BITS-1:0] anchor_y_r, anchor_y_nxt;
  logic [31:0]           anchor_t_r, anchor_t_nxt;
  logic [31:0]           last_upd_r, last_upd_nxt;

  // per-item intermediates
  logic [31:0]           elapsed_r;
  logic                  poll_ok_r;
  logic                  near_r;
  logic [DELAY_BITS-1:0] dwell_r, dwell_nxt;
  logic [DELAY_BITS-1:0] rem_r, rem_nxt;
  logic [PROG_BITS-1:0]  num_lo_r, num_lo_nxt;
  logic [PROG_BITS-1:0]  quo_r, quo_nxt;
  logic [3:0]            step_r, step_nxt;

  // pending result
  logic                  res_click_r, res_click_nxt;
  dcd_action_t           res_act_r, res_act_nxt;
  logic [COORD_BITS-1:0] res_sx_r, res_sx_nxt;
  logic [COORD_BITS-1:0] res_sy_r, res_sy_nxt;
  logic [PROG_BITS-1:0]  res_prog_r, res_prog_nxt;

  // output register
  logic                  out_valid_r;
  logic                  out_click_r;
  logic [1:0]            out_act_r;
  logic [COORD_BITS-1:0] out_sx_r, out_sy_r;
  logic [PROG_BITS-1:0]  out_prog_r;

  logic in_xfer, out_free;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  // movement check against the anchor, one sign bit of headroom
  logic signed [DW-1:0] dx, dy;
  logic                 near_now;
  assign dx = $signed({px_r[COORD_BITS-1], px_r}) -
              $signed({anchor_x_r[COORD_BITS-1], anchor_x_r});
  assign dy = $signed({py_r[COORD_BITS-1], py_r}) -
              $signed({anchor_y_r[COORD_BITS-1], anchor_y_r});
  assign near_now = (dx <= MOVE_POS) && (dx >= MOVE_NEG) &&
                    (dy <= MOVE_POS) && (dy >= MOVE_NEG);

  // divider step: shared compare-and-subtract
  logic [DELAY_BITS:0] div_trial;
  logic                div_fits;
  assign div_trial = {rem_r, num_lo_r[PROG_BITS-1]};
  assign div_fits  = div_trial >= {1'b0, delay_r};

  // dwell * 1000 as shifts: x*1024 - x*16 - x*8
  logic [NUM_BITS-1:0] num;
  assign num = {dwell_r, {PROG_BITS{1'b0}}} - {6'd0, dwell_r, 4'd0} - {7'd0, dwell_r, 3'd0};

  // progress distance to the last figure shown
  logic signed [PROG_BITS:0] pdiff;
  logic                      step_big;
  assign pdiff    = $signed({1'b0, quo_r}) - $signed({1'b0, lp_r});
  assign step_big = (pdiff >= (PROG_BITS+1)'(MIN_PROGRESS_STEP)) ||
                    (pdiff <= -(PROG_BITS+1)'(MIN_PROGRESS_STEP));

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  logic go_div;   // decision needs a progress figure

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_CALC;
      S_CALC:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = go_div ? S_MUL : S_OUT;
      S_MUL:    state_nxt = S_DIV;
      S_DIV:    if (step_r == DIV_LAST) state_nxt = S_STEP;
      S_STEP:   state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  always_comb begin
    primed_nxt    = primed_r;
    armed_nxt     = armed_r;
    fired_nxt     = fired_r;
    ind_on_nxt    = ind_on_r;
    lp_valid_nxt  = lp_valid_r;
    lp_nxt        = lp_r;
    anchor_x_nxt  = anchor_x_r;
    anchor_y_nxt  = anchor_y_r;
    anchor_t_nxt  = anchor_t_r;
    last_upd_nxt  = last_upd_r;
    dwell_nxt     = dwell_r;
    rem_nxt       = rem_r;
    num_lo_nxt    = num_lo_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    res_click_nxt = res_click_r;
    res_act_nxt   = res_act_r;
    res_sx_nxt    = res_sx_r;
    res_sy_nxt    = res_sy_r;
    res_prog_nxt  = res_prog_r;
    go_div        = 1'b0;

    case (state_r)
      S_DECIDE: begin
        res_click_nxt = 1'b0;
        res_act_nxt   = ACT_NONE;
        res_sx_nxt    = '0;
        res_sy_nxt    = '0;
        res_prog_nxt  = '0;
        if (cmd_r) begin
          // hotkey: toggle armed, hide when that leaves the block inactive
          armed_nxt = ~armed_r;
          if (armed_r || !enabled_r) begin
            res_act_nxt  = ACT_HIDE;
            ind_on_nxt   = 1'b0;
            lp_valid_nxt = 1'b0;
          end
        end else if (!enabled_r) begin
          if (ind_on_r) begin
            res_act_nxt  = ACT_HIDE;
            ind_on_nxt   = 1'b0;
            lp_valid_nxt = 1'b0;
          end
        end else if (!primed_r) begin
          primed_nxt   = 1'b1;
          anchor_x_nxt = px_r;
          anchor_y_nxt = py_r;
          anchor_t_nxt = now_r;
          fired_nxt    = 1'b0;
        end else if (!near_r) begin
          // moved: re-anchor
          anchor_x_nxt = px_r;
          anchor_y_nxt = py_r;
          anchor_t_nxt = now_r;
          fired_nxt    = 1'b0;
          if (ind_on_r) res_act_nxt = ACT_HIDE;
          ind_on_nxt   = 1'b0;
          lp_valid_nxt = 1'b0;
        end else if (armed_r && !fired_r) begin
          if (elapsed_r >= 32'(total_ms)) begin
            if (ind_on_r) res_act_nxt = ACT_HIDE;
            ind_on_nxt    = 1'b0;
            lp_valid_nxt  = 1'b0;
            res_click_nxt = 1'b1;
            fired_nxt     = 1'b1;
          end else if (elapsed_r >= 32'(settle_ms)) begin
            if (!ind_on_r) begin
              lp_valid_nxt = 1'b0;
              ind_on_nxt   = 1'b1;
              last_upd_nxt = now_r;
              res_act_nxt  = ACT_SHOW;
              res_sx_nxt   = px_r;
              res_sy_nxt   = py_r;
            end else if (poll_ok_r) begin
              // here elapsed < settle + delay, so the dwell fits the delay width
              dwell_nxt = DELAY_BITS'(elapsed_r - 32'(settle_ms));
              go_div    = 1'b1;
            end
          end
        end else if (ind_on_r) begin
          res_act_nxt  = ACT_HIDE;
          ind_on_nxt   = 1'b0;
          lp_valid_nxt = 1'b0;
        end
      end

      S_MUL: begin
        // numerator < delay * 1024, so the upper part is already a remainder
        rem_nxt    = num[NUM_BITS-1:PROG_BITS];
        num_lo_nxt = num[PROG_BITS-1:0];
        quo_nxt    = '0;
        step_nxt   = '0;
      end

      S_DIV: begin
        rem_nxt    = div_fits ? DELAY_BITS'(div_trial - {1'b0, delay_r})
                              : div_trial[DELAY_BITS-1:0];
        quo_nxt    = {quo_r[PROG_BITS-2:0], div_fits};
        num_lo_nxt = {num_lo_r[PROG_BITS-2:0], 1'b0};
        step_nxt   = step_r + 4'd1;
      end

      S_STEP: begin
        if (!lp_valid_r || step_big) begin
          res_act_nxt  = ACT_UPDATE;
          res_prog_nxt = quo_r;
          lp_nxt       = quo_r;
          lp_valid_nxt = 1'b1;
          last_upd_nxt = now_r;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= 1'b0;
      armed_r     <= 1'b1;
      fired_r     <= 1'b0;
      ind_on_r    <= 1'b0;
      lp_valid_r  <= 1'b0;
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      anchor_t_r  <= '0;
      last_upd_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      armed_r     <= armed_nxt;
      fired_r     <= fired_nxt;
      ind_on_r    <= ind_on_nxt;
      lp_valid_r  <= lp_valid_nxt;
      anchor_x_r  <= anchor_x_nxt;
      anchor_y_r  <= anchor_y_nxt;
      anchor_t_r  <= anchor_t_nxt;
      last_upd_r  <= last_upd_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_cmd;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      now_r <= in_now_ms;
    end
    if (state_r == S_CALC) begin
      elapsed_r <= now_r - anchor_t_r;
      poll_ok_r <= (now_r - last_upd_r) >= 32'(UPDATE_INTERVAL_MS);
      near_r    <= near_now;
    end
    lp_r        <= lp_nxt;
    dwell_r     <= dwell_nxt;
    rem_r       <= rem_nxt;
    num_lo_r    <= num_lo_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    res_click_r <= res_click_nxt;
    res_act_r   <= res_act_nxt;
    res_sx_r    <= res_sx_nxt;
    res_sy_r    <= res_sy_nxt;
    res_prog_r  <= res_prog_nxt;
    if (state_r == S_OUT && out_free) begin
      out_click_r <= res_click_r;
      out_act_r   <= res_act_r;
      out_sx_r    <= res_sx_r;
      out_sy_r    <= res_sy_r;
      out_prog_r  <= res_prog_r;
    end
  end

  // ---------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------
  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_click             = out_click_r;
  assign out_indicator_action  = out_act_r;
  assign out_show_x            = out_sx_r;
  assign out_show_y            = out_sy_r;
  assign out_progress_permille = out_prog_r;

endmodule

`default_nettype wire

FILE: verif/dwell_click_detector_unit_test.sv
// Self-checking testbench for dwell_click_detector_unit: directed and random
// pointer samples and hotkeys, with a cycle-free model of the dwell logic.
// Depends on dcd_pkg and the dwell_click_detector_unit RTL.

module dwell_click_detector_unit_test
  import dcd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int XY_BITS     = 16;
  // Longest legal quiet spell is a long sender gap plus a long receiver
  // stall plus a register update; this is several times that.
  localparam int QUIET_LIMIT = 1000;

  localparam bit CMD_SAMPLE = 1'b0;
  localparam bit CMD_HOTKEY = 1'b1;

  // ---------------------------------------------------------------------------
  // Dwell model and expected-outcome queue
  // ---------------------------------------------------------------------------
  class click_outcome_board;
    typedef struct {
      bit                        click;
      dcd_action_t               action;
      logic signed [XY_BITS-1:0] sx;
      logic signed [XY_BITS-1:0] sy;
      logic [PROG_BITS-1:0]      prog;
    } outcome_t;

    // register shadows
    bit                   enabled;
    bit [DELAY_BITS-1:0]  dwell_delay;
    bit [SETTLE_BITS-1:0] settle_s;

    // tracker state
    bit                        primed;
    logic signed [XY_BITS-1:0] anchor_x;
    logic signed [XY_BITS-1:0] anchor_y;
    logic [31:0]               anchor_t;
    bit                        fired;
    bit                        ind_on;
    logic [31:0]               last_upd_t;
    int                        last_prog;
    bit                        armed;

    outcome_t due[$];
    int       errors;

    function new();
      enabled     = 1'b0;
      dwell_delay = DWELL_RESET;
      settle_s    = SETTLE_RESET;
      primed      = 1'b0;
      anchor_x    = '0;
      anchor_y    = '0;
      anchor_t    = '0;
      fired       = 1'b0;
      ind_on      = 1'b0;
      last_upd_t  = '0;
      last_prog   = -1;
      armed       = 1'b1;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ENABLED: enabled     = value[0];
        REG_DWELL:   dwell_delay = value[DELAY_BITS-1:0];
        REG_SETTLE:  settle_s    = value[SETTLE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_ENABLED: return 32'(enabled);
        REG_DWELL:   return 32'(dwell_delay);
        REG_SETTLE:  return 32'(settle_s);
        default:     return '0;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function dcd_action_t hide();
      ind_on    = 1'b0;
      last_prog = -1;
      return ACT_HIDE;
    endfunction

    function bit near(logic signed [XY_BITS-1:0] a, logic signed [XY_BITS-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d <= MOVE_THRESHOLD) && (d >= -MOVE_THRESHOLD);
    endfunction

    // Work out the one outcome of an accepted item and queue it.
    function void note_item(bit cmd, logic signed [XY_BITS-1:0] px,
                            logic signed [XY_BITS-1:0] py, logic [31:0] now);
      outcome_t        o;
      logic [31:0]     elapsed;
      logic [31:0]     settle_ms;
      logic [31:0]     total;
      logic [31:0]     dwell;
      longint unsigned pm;
      int              delta;
      o.click  = 1'b0;
      o.action = ACT_NONE;
      o.sx     = '0;
      o.sy     = '0;
      o.prog   = '0;
      if (cmd == CMD_HOTKEY) begin
        armed = !armed;
        if (!armed || !enabled) o.action = hide();
      end else if (!enabled) begin
        if (ind_on) o.action = hide();
      end else if (!primed) begin
        primed   = 1'b1;
        anchor_x = px;
        anchor_y = py;
        anchor_t = now;
        fired    = 1'b0;
      end else if (!near(px, anchor_x) || !near(py, anchor_y)) begin
        anchor_x = px;
        anchor_y = py;
        anchor_t = now;
        fired    = 1'b0;
        if (ind_on) o.action = ACT_HIDE;
        ind_on    = 1'b0;
        last_prog = -1;
      end else if (armed && !fired) begin
        elapsed   = now - anchor_t;
        settle_ms = 32'(settle_s) * 32'(MS_PER_SECOND);
        total     = settle_ms + 32'(dwell_delay);
        if (elapsed >= total) begin
          if (ind_on) o.action = ACT_HIDE;
          ind_on    = 1'b0;
          last_prog = -1;
          o.click   = 1'b1;
          fired     = 1'b1;
        end else if (elapsed >= settle_ms) begin
          dwell = elapsed - settle_ms;
          if (!ind_on) begin
            last_prog  = -1;
            ind_on     = 1'b1;
            last_upd_t = now;
            o.action   = ACT_SHOW;
            o.sx       = px;
            o.sy       = py;
          end else if (32'(now - last_upd_t) >= 32'(UPDATE_INTERVAL_MS)) begin
            pm = PERMILLE_FULL;
            if (dwell_delay != 0)
              pm = (64'(dwell) * 64'(PERMILLE_FULL)) / 64'(dwell_delay);
            if (pm > PERMILLE_FULL) pm = PERMILLE_FULL;
            delta = int'(pm) - last_prog;
            if (delta < 0) delta = -delta;
            if (last_prog < 0 || delta >= MIN_PROGRESS_STEP) begin
              o.action   = ACT_UPDATE;
              o.prog     = pm[PROG_BITS-1:0];
              last_prog  = int'(pm);
              last_upd_t = now;
            end
          end
        end
      end else if (ind_on) begin
        o.action = hide();
      end
      due.push_back(o);
    endfunction

    function void compare_field(string name, int exp_val, logic signed [31:0] got);
      if (got !== exp_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, got);
        errors++;
      end
    endfunction

    function void check_outcome(logic click, logic [1:0] action,
                                logic signed [XY_BITS-1:0] sx,
                                logic signed [XY_BITS-1:0] sy,
                                logic [PROG_BITS-1:0] prog);
      outcome_t e;
      if (due.size() == 0) begin
        $error("result transfer with no outcome pending");
        errors++;
        return;
      end
      e = due.pop_front();
      compare_field("click", int'(e.click), click);
      compare_field("indicator_action", int'(e.action), action);
      compare_field("show_x", int'(e.sx), sx);
      compare_field("show_y", int'(e.sy), sy);
      compare_field("progress_permille", int'(e.prog), prog);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals and the block under test
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  logic                      in_valid;
  logic                      in_stall;
  logic                      in_cmd;
  logic signed [XY_BITS-1:0] in_pos_x;
  logic signed [XY_BITS-1:0] in_pos_y;
  logic [31:0]               in_now_ms;

  logic                      out_valid;
  logic                      out_stall;
  logic                      out_click;
  logic [1:0]                out_indicator_action;
  logic signed [XY_BITS-1:0] out_show_x;
  logic signed [XY_BITS-1:0] out_show_y;
  logic [PROG_BITS-1:0]      out_progress_permille;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  click_outcome_board board;

  // when set, neither side inserts gaps or stalls
  bit          calm;
  int          stall_left;
  int unsigned quiet_cycles;
  logic [31:0] tick;

  dwell_click_detector_unit #(.COORD_BITS(XY_BITS)) uut (.*);

  always #HALF_PERIOD clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stall bursts, changed only at the falling edge.
  always @(negedge clk) begin
    if (stall_left == 0) stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Result transfers are checked against the oldest pending outcome.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_outcome(out_click, out_indicator_action, out_show_x, out_show_y,
                          out_progress_permille);
  end

  // Watchdog: any transfer on either channel resets the quiet count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[dwell_click_detector_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One input transfer. Valid stays high into the next item when no gap is
  // drawn, so back-to-back transfers happen.
  task automatic send_item(bit cmd, logic signed [XY_BITS-1:0] x,
                           logic signed [XY_BITS-1:0] y, logic [31:0] t);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_cmd    = cmd;
    in_pos_x  = x;
    in_pos_y  = y;
    in_now_ms = t;
    do @(posedge clk); while (in_stall);
    board.note_item(cmd, x, y, t);
  endtask

  // Hold the sender off until every pending outcome has been delivered.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // APB write, then read back, back to back with psel held.
  task automatic set_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== board.reg_value(idx)) begin
      $error("register %0d readback: expected %0d, got %0d", idx,
             board.reg_value(idx), prdata);
      board.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Registers change only with the block idle. Junk above each field checks
  // that the block keeps only the low bits.
  task automatic apply_settings(bit en, int dwell, int settle);
    logic [31:0] junk;
    drain();
    repeat (4) @(negedge clk);
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    set_reg(REG_ENABLED, (junk << 1) | 32'(en));
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    set_reg(REG_DWELL, (junk << DELAY_BITS) | 32'(dwell));
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    set_reg(REG_SETTLE, (junk << SETTLE_BITS) | 32'(settle));
  endtask

  // Random traffic: mostly still-pointer sessions that walk through settle,
  // show, progress and click, broken up by moves, hotkeys and noise.
  task automatic run_phase(int n_items);
    int                        sent;
    int                        len;
    int                        dx;
    int                        dy;
    int                        r;
    int unsigned               span;
    logic signed [XY_BITS-1:0] ax;
    logic signed [XY_BITS-1:0] ay;
    sent = 0;
    // ordinary time steps run up to about a fifteenth of settle plus dwell, plus 60 ms
    span = (32'(board.settle_s) * MS_PER_SECOND + board.dwell_delay) / 15 + 60;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(CMD_HOTKEY, XY_BITS'($urandom), XY_BITS'($urandom), $urandom);
        sent++;
      end else if (r < 12) begin
        send_item(CMD_SAMPLE, XY_BITS'($urandom), XY_BITS'($urandom), $urandom);
        sent++;
      end else if (r < 14) begin
        drain();
      end else begin
        ax = XY_BITS'($urandom);
        ay = XY_BITS'($urandom);
        if ($urandom_range(0, 7) == 0) ax = 16'sh7FFE;
        if ($urandom_range(0, 7) == 0) ay = -16'sh7FFF;
        // sometimes start just short of the tick wrap
        if ($urandom_range(0, 9) == 0) tick = 32'hFFFF_FFFF - $urandom_range(0, span * 4);
        len = $urandom_range(4, 40);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            send_item(CMD_HOTKEY, XY_BITS'($urandom), XY_BITS'($urandom), $urandom);
          end else begin
            dx = int'($urandom_range(0, 10)) - 5;
            dy = int'($urandom_range(0, 10)) - 5;
            if (r < 7) dx = $urandom_range(0, 1) ? 6 : -6;
            else if (r < 10) dy = $urandom_range(0, 1) ? 6 : -6;
            if ($urandom_range(0, 39) == 0) tick += $urandom;
            else tick += $urandom_range(0, span);
            send_item(CMD_SAMPLE, XY_BITS'(ax + dx), XY_BITS'(ay + dy), tick);
            // a break past the threshold moves the anchor with it
            if (dx > MOVE_THRESHOLD || dx < -MOVE_THRESHOLD ||
                dy > MOVE_THRESHOLD || dy < -MOVE_THRESHOLD) begin
              ax = XY_BITS'(ax + dx);
              ay = XY_BITS'(ay + dy);
            end
          end
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] t0;
    bit          ph_en[7];
    int          ph_dwell[7];
    int          ph_settle[7];
    int          ph_items[7];
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_SAMPLE;
    in_pos_x   = '0;
    in_pos_y   = '0;
    in_now_ms  = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    stall_left = 0;
    tick       = $urandom;
    board      = new();
    t0         = 32'hFFFF_FE00;

    // default, short, zero delay, both maxima, typical, disabled, tiny
    ph_en     = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    ph_dwell  = '{1000, 500, 0, 16383, 10000, 700, 1};
    ph_settle = '{1, 1, 0, 7, 5, 2, 3};
    ph_items  = '{90, 90, 90, 90, 90, 40, 90};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Disabled after reset: quiet sample, then hotkeys hide either way.
    send_item(CMD_SAMPLE, 0, 0, 0);
    send_item(CMD_HOTKEY, -1, -1, 32'hFFFF_FFFF);
    send_item(CMD_HOTKEY, 0, 0, 0);

    apply_settings(1'b1, 1000, 1);
    // first sample only anchors, at the coordinate extremes, just before wrap
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0);
    send_item(CMD_SAMPLE, -16'sh7FFB, 16'sh7FFA, t0 + 32'd500);    // edge of still
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1000);   // show
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1020);   // too soon
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1300);   // progress
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1310);
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1360);
    send_item(CMD_HOTKEY, 0, 0, 0);                                // disarm, hide
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1500);
    send_item(CMD_HOTKEY, 0, 0, 0);                                // rearm
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd1600);   // show again
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd2000);   // click + hide
    send_item(CMD_SAMPLE, -16'sh8000, 16'sh7FFF, t0 + 32'd2100);   // already fired
    send_item(CMD_SAMPLE, -16'sh7FFA, 16'sh7FFF, t0 + 32'd2200);   // move, re-anchor
    send_item(CMD_SAMPLE, -16'sh7FFA, 16'sh7FFF, t0 + 32'd3200);   // show
    send_item(CMD_SAMPLE, 16'sh7FFF, -16'sh8000, t0 + 32'd3300);   // move with hide
    drain();
    send_item(CMD_SAMPLE, 16'sh7FFF, -16'sh8000, t0 + 32'd4300);   // show

    // disabled with the indicator up, then hotkeys while disabled
    apply_settings(1'b0, 1000, 1);
    send_item(CMD_SAMPLE, 16'sh7FFF, -16'sh8000, t0 + 32'd4400);
    send_item(CMD_HOTKEY, 0, 0, 0);
    send_item(CMD_HOTKEY, 0, 0, 0);

    // zero settle and zero dwell: the click is immediate
    apply_settings(1'b1, 0, 0);
    send_item(CMD_SAMPLE, 100, 100, 32'd5);
    send_item(CMD_SAMPLE, 100, 100, 32'd5);

    for (int p = 0; p < 7; p++) begin
      apply_settings(ph_en[p], ph_dwell[p], ph_settle[p]);
      calm = ($urandom_range(0, 3) == 0);
      run_phase(ph_items[p]);
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("[dwell_click_detector_unit] OK");
    else
      $display("[dwell_click_detector_unit] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
src/dcd_pkg.sv
src/dwell_click_detector_unit.sv
verif/dwell_click_detector_unit_test.sv
